FILE: rtl/core/sorted_priority_queue_core_macros.svh
// Assertion macros for the sorted priority queue core.
// Included by RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// Shared types for the sorted priority queue core.
// No dependencies; imported by spq_cell, sorted_priority_queue_core and the bench.
package spq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NOP  = 2'd3
  } spq_mode_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_cmd_t;

endpackage

FILE: rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue: one command (enqueue, dequeue, peek, no-op) per clock, built as a chain
// of cells that all compare against the incoming priority at once. A command is taken
// when start_i is high; busy_o is always low, so a new command may come every cycle.
// Each command gives exactly one result, shown on the result ports with done_o as a one-cycle
// strobe in the cycle after the command; the receiver cannot stall it. The result is taken
// from the head cell into the result registers. Ties leave in arrival order.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_macros.svh.
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  mode_i,
  input  logic signed [DataW-1:0]     in_value_i,
  input  logic signed [DataW-1:0]     in_priority_i,
  output logic                        done_o,
  output logic signed [DataW-1:0]     out_value_o,
  output logic signed [DataW-1:0]     out_priority_o,
  output logic [CountOutW-1:0]        entry_count_o,
  output logic                        empty_error_o,
  output logic                        full_error_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            accept;
  spq_mode_e       mode;
  spq_entry_t      new_entry;
  spq_cmd_t        cmd;
  spq_entry_t      cell_q [CAPACITY];
  logic            keep   [CAPACITY];
  logic [CntW-1:0] count_q, count_d;
  logic            is_empty, is_full;

  logic                    done_q;
  logic signed [DataW-1:0] value_q, value_d;
  logic signed [DataW-1:0] prio_q, prio_d;
  logic                    empty_err_q, empty_err_d;
  logic                    full_err_q, full_err_d;
  logic [CntW+CountOutW-1:0] count_wide;

  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign mode      = spq_mode_e'(mode_i);
  assign new_entry = '{value: in_value_i, prio: in_priority_i};
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q >= CntW'(CAPACITY));

  always_comb begin
    cmd         = '0;
    count_d     = count_q;
    value_d     = '0;
    prio_d      = '0;
    empty_err_d = 1'b0;
    full_err_d  = 1'b0;
    if (accept) begin
      case (mode)
        MODE_ENQ: begin
          if (is_full) begin
            full_err_d = 1'b1;
          end else begin
            cmd.enq = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        MODE_DEQ, MODE_PEEK: begin
          if (is_empty) begin
            empty_err_d = 1'b1;
          end else begin
            value_d = cell_q[0].value;
            prio_d  = cell_q[0].prio;
            if (mode == MODE_DEQ) begin
              cmd.deq = 1'b1;
              count_d = count_q - CntW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left, right;
    logic       left_keep;
    if (i == 0) begin : g_head
      assign left      = new_entry;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left      = cell_q[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = cell_q[i];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .new_i       (new_entry),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .valid_i     (count_q > CntW'(i)),
      .entry_o     (cell_q[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    prio_q      <= prio_d;
    empty_err_q <= empty_err_d;
    full_err_q  <= full_err_d;
  end

  // Count reported modulo 32.
  assign count_wide     = {{CountOutW{1'b0}}, count_q};
  assign done_o         = done_q;
  assign out_value_o    = value_q;
  assign out_priority_o = prio_q;
  assign entry_count_o  = count_wide[CountOutW-1:0];
  assign empty_error_o  = empty_err_q;
  assign full_error_o   = full_err_q;

  `SPQ_ASSERT(a_count_max, count_q <= CntW'(CAPACITY), "occupancy above capacity")
  `SPQ_ASSERT_NXT(a_done_follows, accept, done_o, "result strobe missing after transfer")
  `SPQ_ASSERT_IMP(a_err_excl, done_o, !(empty_error_o && full_error_o), "both error flags set")
  `SPQ_ASSERT_IMP(a_empty_cnt, done_o && empty_error_o, count_q == '0, "empty error with entries")
  `SPQ_ASSERT_IMP(a_head_sorted, count_q >= CntW'(2), cell_q[0].prio >= cell_q[1].prio,
                  "head outranked by second entry")

endmodule

FILE: rtl/core/spq_cell.sv
// One slot of the systolic sorted list: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  spq_cmd_t   cmd_i,
  input  spq_entry_t new_i,
  input  spq_entry_t left_i,
  input  logic       left_keep_i,
  input  spq_entry_t right_i,
  input  logic       valid_i,
  output spq_entry_t entry_o,
  output logic       keep_o
);

  spq_entry_t entry_q, entry_d;

  // Entry stays put on insert when it ranks equal or above the new one.
  assign keep_o = valid_i && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? new_i : left_i;
      end
    end else if (cmd_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: bench/sorted_priority_queue_core_test.sv
// Self-checking bench for sorted_priority_queue_core: directed and random enqueue,
// dequeue, peek and no-op commands, checked against a sorted-list model of the queue.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned QDepth     = 16;
  localparam int unsigned RandomOps  = 830;
  localparam int unsigned MaxGap     = 14;
  localparam int unsigned SettleCyc  = 5;
  localparam int unsigned StallLimit = 400;

  localparam logic signed [DataW-1:0] PrioMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] PrioMin = 32'sh8000_0000;

  typedef enum int unsigned {
    FILL_BURST,
    DRAIN_BURST,
    MIXED_BURST
  } burst_kind_e;

  typedef struct {
    spq_mode_e               mode;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
    int unsigned             gap;
    bit                      wait_drained;
  } queue_cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
    logic [CountOutW-1:0]    count;
    logic                    empty_err;
    logic                    full_err;
  } queue_resp_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [1:0]              mode_i = MODE_NOP;
  logic signed [DataW-1:0] in_value_i = '0;
  logic signed [DataW-1:0] in_priority_i = '0;
  logic                    done_o;
  logic signed [DataW-1:0] out_value_o;
  logic signed [DataW-1:0] out_priority_o;
  logic [CountOutW-1:0]    entry_count_o;
  logic                    empty_error_o;
  logic                    full_error_o;

  sorted_priority_queue_core #(
    .CAPACITY(QDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .in_value_i     (in_value_i),
    .in_priority_i  (in_priority_i),
    .done_o         (done_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .entry_count_o  (entry_count_o),
    .empty_error_o  (empty_error_o),
    .full_error_o   (full_error_o)
  );

  // Model of the queue contents, highest priority at index 0.
  spq_entry_t  model_list [QDepth];
  int unsigned model_count = 0;

  queue_cmd_t  pending_q [$];
  queue_resp_t expected_q [$];
  queue_cmd_t  cur_cmd;
  int unsigned idle_run = 0;

  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_full_drops = 0;
  int unsigned n_empty_hits = 0;
  int unsigned n_by_mode [4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic queue_resp_t apply_to_model(input queue_cmd_t cmd);
    queue_resp_t r;
    int unsigned pos;
    r = '0;
    case (cmd.mode)
      MODE_ENQ: begin
        if (model_count >= QDepth) begin
          r.full_err = 1'b1;
          n_full_drops++;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < model_count && $signed(model_list[pos].prio) >= $signed(cmd.prio))
            pos++;
          for (int unsigned i = model_count; i > pos; i--) model_list[i] = model_list[i-1];
          model_list[pos].value = cmd.value;
          model_list[pos].prio  = cmd.prio;
          model_count++;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (model_count == 0) begin
          r.empty_err = 1'b1;
          n_empty_hits++;
        end else begin
          r.value = model_list[0].value;
          r.prio  = model_list[0].prio;
          if (cmd.mode == MODE_DEQ) begin
            for (int unsigned i = 0; i + 1 < model_count; i++) model_list[i] = model_list[i+1];
            model_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = model_count[CountOutW-1:0];
    return r;
  endfunction

  task automatic add_cmd(input spq_mode_e mode, input logic signed [DataW-1:0] value,
                         input logic signed [DataW-1:0] prio, input int unsigned gap,
                         input bit wait_drained);
    queue_cmd_t c;
    c.mode         = mode;
    c.value        = value;
    c.prio         = prio;
    c.gap          = gap;
    c.wait_drained = wait_drained;
    pending_q.insert(pending_q.size(), c);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Driver: one transfer per start_i/!busy_o edge, gap counted from the last transfer.
  always @(posedge clk_i) begin
    bit fire;
    if (rst_ni) begin
      fire = start_i && !busy_o;
      if (fire) begin
        expected_q.insert(expected_q.size(), apply_to_model(cur_cmd));
        n_by_mode[cur_cmd.mode]++;
        idle_run = 0;
      end
      if (start_i && !fire) begin
        // command held until the block takes it
      end else if (pending_q.size() != 0 && idle_run >= pending_q[0].gap &&
                   !(pending_q[0].wait_drained && expected_q.size() != 0)) begin
        cur_cmd = pending_q.pop_front();
        start_i       <= 1'b1;
        mode_i        <= cur_cmd.mode;
        in_value_i    <= cur_cmd.value;
        in_priority_i <= cur_cmd.prio;
      end else begin
        // junk on the data lines while idle; the block must ignore it
        start_i       <= 1'b0;
        in_value_i    <= $urandom();
        in_priority_i <= $urandom();
        idle_run++;
      end
    end
  end

  // Monitor: done_o marks a single-cycle result that cannot be held off.
  always @(posedge clk_i) begin
    queue_resp_t want;
    if (rst_ni && done_o) begin
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d priority %0d count %0d", out_value_o,
               out_priority_o, entry_count_o);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_value", want.value, out_value_o);
        check_field("out_priority", want.prio, out_priority_o);
        check_field("entry_count", want.count, entry_count_o);
        check_field("empty_error", want.empty_err, empty_error_o);
        check_field("full_error", want.full_err, full_error_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("sorted_priority_queue_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic signed [DataW-1:0] extreme_prios [6];
    logic signed [DataW-1:0] fill_prios [5];
    logic signed [DataW-1:0] prio;
    burst_kind_e kind;
    spq_mode_e   mode;
    int unsigned made;
    int unsigned burst_len;
    int unsigned pace;
    int unsigned roll;
    int unsigned enq_pct;
    int unsigned deq_pct;
    int unsigned peek_pct;
    int unsigned gap;

    extreme_prios = '{PrioMin, PrioMin + 1, -1, 0, PrioMax - 1, PrioMax};
    fill_prios    = '{PrioMax, 0, -1, PrioMin, 3};

    // empty queue: every head access flags, no-op reports zero
    add_cmd(MODE_PEEK, 32'sh5a5a_5a5a, -1, 0, 1'b0);
    add_cmd(MODE_DEQ, -1, 1, 0, 1'b0);
    add_cmd(MODE_NOP, PrioMax, PrioMin, 0, 1'b0);
    // field extremes and a tie on priority 0
    add_cmd(MODE_ENQ, PrioMax, PrioMin, 0, 1'b0);
    add_cmd(MODE_ENQ, PrioMin, PrioMax, 0, 1'b0);
    add_cmd(MODE_ENQ, 10, 0, 1, 1'b0);
    add_cmd(MODE_ENQ, 11, 0, 0, 1'b0);
    add_cmd(MODE_ENQ, -1, -1, 0, 1'b0);
    add_cmd(MODE_PEEK, 0, 0, 3, 1'b0);
    add_cmd(MODE_NOP, -1, -1, 0, 1'b0);
    // fill to capacity, then overflow
    for (int unsigned i = 0; i < QDepth - 4; i++)
      add_cmd(MODE_ENQ, 100 + i, fill_prios[i % 5], 0, 1'b0);
    add_cmd(MODE_ENQ, 999, PrioMax, 0, 1'b0);
    add_cmd(MODE_DEQ, 0, 0, 0, 1'b0);
    add_cmd(MODE_DEQ, 0, 0, 2, 1'b0);

    // bursts biased toward filling or draining so both full and empty recur
    made = 0;
    while (made < RandomOps) begin
      burst_len = $urandom_range(8, 40);
      kind      = burst_kind_e'($urandom_range(0, 2));
      pace      = $urandom_range(0, 2);
      case (kind)
        FILL_BURST:  begin enq_pct = 75; deq_pct = 15; peek_pct = 7;  end
        DRAIN_BURST: begin enq_pct = 20; deq_pct = 65; peek_pct = 12; end
        default:     begin enq_pct = 40; deq_pct = 35; peek_pct = 22; end
      endcase
      for (int unsigned k = 0; k < burst_len && made < RandomOps; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) mode = MODE_ENQ;
        else if (roll < enq_pct + deq_pct) mode = MODE_DEQ;
        else if (roll < enq_pct + deq_pct + peek_pct) mode = MODE_PEEK;
        else mode = MODE_NOP;
        roll = $urandom_range(0, 9);
        if (roll < 4) prio = $signed($urandom_range(0, 4)) - 2;
        else if (roll < 6) prio = extreme_prios[$urandom_range(0, 5)];
        else prio = $urandom();
        case (pace)
          0:       gap = 0;
          1:       gap = $urandom_range(0, MaxGap);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxGap) : 0;
        endcase
        add_cmd(mode, $urandom(), prio, gap, made == 0 || $urandom_range(0, 99) == 0);
        made++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("commands: %0d enqueue, %0d dequeue, %0d peek, %0d no-op; %0d results checked",
             n_by_mode[MODE_ENQ], n_by_mode[MODE_DEQ], n_by_mode[MODE_PEEK],
             n_by_mode[MODE_NOP], n_checked);
    $display("overflow drops on a full queue: %0d, head accesses on an empty queue: %0d",
             n_full_drops, n_empty_hits);
    if (n_errors == 0) begin
      $display("sorted_priority_queue_core regression: pass");
    end else begin
      $display("sorted_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_test.sv
